// File: hw/rtl/particle_density_step_macros.svh
// ----------------------------------------------------------------------------
// particle_density_step_macros.svh
// Assertion macros used by the particle density sequencer.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_DENSITY_STEP_MACROS_SVH
`define PARTICLE_DENSITY_STEP_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define PDS_ASSERT_SAME(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// Condition c must hold in the cycle after a.
`define PDS_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

// File: hw/rtl/pds_pkg.sv
// ----------------------------------------------------------------------------
// pds_pkg
// Types, codes and constants shared by the particle density block.
// ----------------------------------------------------------------------------
`default_nettype none

package pds_pkg;

    // Default particle store depth.
    localparam int PARTICLES_DEF = 256;

    // Field widths.
    localparam int Q_W     = 20;   // Q11.8 position / velocity
    localparam int DENS_W  = 24;   // Q16.8 density
    localparam int GRAD_W  = 25;   // Q16.8 gradient
    localparam int D_W     = 22;   // distance component
    localparam int SQ_IN_W = 42;   // squared distance
    localparam int SQ_OUT_W = 21;  // distance

    // Actions.
    localparam logic [2:0] ACT_LOAD  = 3'd0;
    localparam logic [2:0] ACT_ACCEL = 3'd1;
    localparam logic [2:0] ACT_STEP  = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_QUERY = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AREA_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_AREA_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_PART_RADIUS = 3'd2;
    localparam logic [2:0] CFG_WALL_DAMP   = 3'd3;
    localparam logic [2:0] CFG_PUSH_SCALE  = 3'd4;
    localparam logic [2:0] CFG_KERN_RADIUS = 3'd5;
    localparam logic [2:0] CFG_ACTIVE_CNT  = 3'd6;

    // Density sample points: center, one pixel right, one pixel down.
    localparam logic [1:0] SMP_C = 2'd0;
    localparam logic [1:0] SMP_X = 2'd1;
    localparam logic [1:0] SMP_Y = 2'd2;

    // Datapath operations.
    typedef logic [4:0] t_dp_op;
    localparam t_dp_op DP_NOP     = 5'd0;
    localparam t_dp_op DP_CAPTURE = 5'd1;
    localparam t_dp_op DP_LOAD_WR = 5'd2;
    localparam t_dp_op DP_RD      = 5'd3;
    localparam t_dp_op DP_RD_OUT  = 5'd4;
    localparam t_dp_op DP_ACC_WR  = 5'd5;
    localparam t_dp_op DP_MOVE    = 5'd6;
    localparam t_dp_op DP_MUL_X   = 5'd7;
    localparam t_dp_op DP_MUL_Y   = 5'd8;
    localparam t_dp_op DP_SQ_ADD  = 5'd9;
    localparam t_dp_op DP_TERM    = 5'd10;
    localparam t_dp_op DP_PUSH_X  = 5'd11;
    localparam t_dp_op DP_PUSH_Y  = 5'd12;
    localparam t_dp_op DP_WALL_XR = 5'd13;
    localparam t_dp_op DP_WALL_XL = 5'd14;
    localparam t_dp_op DP_WALL_YR = 5'd15;
    localparam t_dp_op DP_WALL_YL = 5'd16;
    localparam t_dp_op DP_ST_WR   = 5'd17;
    localparam t_dp_op DP_Q_OUT   = 5'd18;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] smp;
    } t_cmd;

    typedef struct packed {
        logic sq_done;
    } t_sts;

    typedef struct packed {
        logic [10:0] area_width;
        logic [10:0] area_height;
        logic [3:0]  particle_radius;
        logic [7:0]  wall_damping;
        logic [15:0] push_scale;
        logic [7:0]  kern_reach;
        logic [8:0]  active_count;
    } t_cfg;

endpackage

`default_nettype wire

// File: hw/rtl/pds_isqrt.sv
// ----------------------------------------------------------------------------
// pds_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_isqrt
    import pds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SQ_IN_W-1:0]  i_n,
    output logic                o_done,
    output logic [SQ_OUT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [SQ_IN_W-1:0]  r_n;
    logic [SQ_OUT_W+1:0] r_rem;
    logic [SQ_OUT_W-1:0] r_root;

    logic [SQ_OUT_W+3:0] rem_t;
    logic [SQ_OUT_W+3:0] trial;
    logic                fits;

    // Bring down two bits and try the next root bit.
    always_comb begin
        rem_t = {r_rem, r_n[SQ_IN_W-1 -: 2]};
        trial = {2'b00, r_root, 2'b01};
        fits  = (rem_t >= trial);
    end

    // Control: busy until every root bit has been produced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(SQ_OUT_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    // Remainder and root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n <= {r_n[SQ_IN_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= (SQ_OUT_W + 2)'(rem_t - trial);
                r_root <= {r_root[SQ_OUT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_t[SQ_OUT_W+1:0];
                r_root <= {r_root[SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = !r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hw/rtl/pds_dp.sv
// ----------------------------------------------------------------------------
// pds_dp
// Datapath: particle stores, distance and density arithmetic, step updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pds_dp
    import pds_pkg::*;
#(
    parameter int P = PARTICLES_DEF,
    localparam int AW = (P > 1) ? $clog2(P) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_cmd                     i_cmd,
    input  logic [AW-1:0]            i_addr,
    input  logic signed [Q_W-1:0]    i_load_x,
    input  logic signed [Q_W-1:0]    i_load_y,
    input  logic signed [Q_W-1:0]    i_load_vel_x,
    input  logic signed [Q_W-1:0]    i_load_vel_y,
    input  logic signed [Q_W-1:0]    i_accel_x,
    input  logic signed [Q_W-1:0]    i_accel_y,
    input  logic [10:0]              i_query_x,
    input  logic [10:0]              i_query_y,
    output t_sts                     o_sts,
    output logic signed [Q_W-1:0]    o_out_x,
    output logic signed [Q_W-1:0]    o_out_y,
    output logic signed [Q_W-1:0]    o_out_vel_x,
    output logic signed [Q_W-1:0]    o_out_vel_y,
    output logic [DENS_W-1:0]        o_density,
    output logic signed [GRAD_W-1:0] o_gradient_x,
    output logic signed [GRAD_W-1:0] o_gradient_y
);

    // Saturate to 20 bits signed.
    function automatic logic signed [Q_W-1:0] sat20(input logic signed [26:0] v);
        if (v > 27'sd524287) begin
            sat20 = 20'sd524287;
        end else if (v < -27'sd524288) begin
            sat20 = -20'sd524288;
        end else begin
            sat20 = v[Q_W-1:0];
        end
    endfunction

    // Stores: {y, x} per entry.
    logic [2*Q_W-1:0] pos_mem [P];
    logic [2*Q_W-1:0] vel_mem [P];

    logic [2*Q_W-1:0] r_pos_rd, r_vel_rd;
    logic signed [Q_W-1:0] r_px, r_py, r_vx, r_vy, r_ax, r_ay;
    logic signed [Q_W-1:0] r_lx, r_ly, r_lvx, r_lvy;
    logic signed [D_W-1:0] r_cx, r_cy;
    logic [SQ_IN_W-1:0] r_prod, r_acc;
    logic [DENS_W-1:0] r_s0, r_s1, r_s2;
    logic signed [Q_W-1:0] r_out_x, r_out_y, r_out_vx, r_out_vy;
    logic [DENS_W-1:0] r_dens;
    logic signed [GRAD_W-1:0] r_gx, r_gy;

    logic signed [Q_W-1:0] rd_px, rd_py, rd_vx, rd_vy;
    logic signed [Q_W-1:0] mv_x, mv_y, acc_x, acc_y;
    logic signed [D_W-1:0] cxs, cys, dx, dy, mul_d;
    logic signed [2*D_W-1:0] prod;
    logic [SQ_IN_W-1:0] sq_n;
    logic sq_start;
    logic [SQ_OUT_W-1:0] root;
    logic signed [D_W-1:0] term_s;
    logic [DENS_W-1:0] s_cur, s_new;
    logic [DENS_W:0] s_add;
    logic signed [GRAD_W-1:0] gx, gy, push_g;
    logic signed [Q_W-1:0] push_v, push_new;
    logic signed [41:0] pprod, psum;
    logic signed [25:0] pr;
    logic wall_y, wall_r, hit;
    logic signed [Q_W-1:0] wall_p, wall_v, bounce_v, wall_newp;
    logic [10:0] ext;
    logic signed [11:0] lim_d;
    logic signed [Q_W-1:0] lim;
    logic signed [28:0] bprod;
    logic signed [29:0] bsum;
    logic we_pos, we_vel;
    logic [2*Q_W-1:0] wd_pos, wd_vel;

    // Read data fields, move and accelerate.
    always_comb begin
        rd_px = r_pos_rd[Q_W-1:0];
        rd_py = r_pos_rd[2*Q_W-1:Q_W];
        rd_vx = r_vel_rd[Q_W-1:0];
        rd_vy = r_vel_rd[2*Q_W-1:Q_W];
        mv_x  = sat20(27'(rd_px) + 27'(rd_vx));
        mv_y  = sat20(27'(rd_py) + 27'(rd_vy));
        acc_x = sat20(27'(rd_vx) + 27'(r_ax));
        acc_y = sat20(27'(rd_vy) + 27'(r_ay));
    end

    // Distance components and the shared squaring multiplier.
    always_comb begin
        cxs   = r_cx + ((i_cmd.smp == SMP_X) ? 22'sd256 : 22'sd0);
        cys   = r_cy + ((i_cmd.smp == SMP_Y) ? 22'sd256 : 22'sd0);
        dx    = D_W'(rd_px) - cxs;
        dy    = D_W'(rd_py) - cys;
        mul_d = (i_cmd.op == DP_MUL_Y) ? dy : dx;
        prod  = mul_d * mul_d;
        sq_n  = r_acc + r_prod;
        sq_start = (i_cmd.op == DP_SQ_ADD);
    end

    pds_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_n),
        .o_done  (o_sts.sq_done),
        .o_root  (root)
    );

    // Kernel term and saturating density sum.
    always_comb begin
        term_s = $signed({6'b0, i_cfg.kern_reach, 8'h00}) - $signed({1'b0, root});
        case (i_cmd.smp)
            SMP_X:   s_cur = r_s1;
            SMP_Y:   s_cur = r_s2;
            default: s_cur = r_s0;
        endcase
        s_add = {1'b0, s_cur} + {9'b0, term_s[15:0]};
        s_new = s_add[DENS_W] ? {DENS_W{1'b1}} : s_add[DENS_W-1:0];
    end

    // Push against the gradient.
    always_comb begin
        gx       = $signed({1'b0, r_s1}) - $signed({1'b0, r_s0});
        gy       = $signed({1'b0, r_s2}) - $signed({1'b0, r_s0});
        push_g   = (i_cmd.op == DP_PUSH_Y) ? gy : gx;
        push_v   = (i_cmd.op == DP_PUSH_Y) ? r_vy : r_vx;
        pprod    = $signed({1'b0, i_cfg.push_scale}) * push_g;
        psum     = pprod + 42'sd32768;
        pr       = psum[41:16];
        push_new = sat20(27'(push_v) - 27'(pr));
    end

    // Wall test and damped bounce.
    always_comb begin
        wall_y    = (i_cmd.op == DP_WALL_YR) || (i_cmd.op == DP_WALL_YL);
        wall_r    = (i_cmd.op == DP_WALL_XR) || (i_cmd.op == DP_WALL_YR);
        wall_p    = wall_y ? r_py : r_px;
        wall_v    = wall_y ? r_vy : r_vx;
        ext       = wall_y ? i_cfg.area_height : i_cfg.area_width;
        lim_d     = $signed({1'b0, ext}) - $signed({8'b0, i_cfg.particle_radius});
        lim       = {lim_d, 8'h00};
        hit       = wall_r ? (wall_p > lim) : (wall_p <= 20'sd0);
        bprod     = wall_v * $signed({1'b0, i_cfg.wall_damping});
        bsum      = -(30'(bprod)) + 30'sd128;
        bounce_v  = sat20(27'($signed(bsum[29:8])));
        wall_newp = wall_r ? lim : 20'sd0;
    end

    // Store write port.
    always_comb begin
        we_pos = 1'b0;
        we_vel = 1'b0;
        wd_pos = {r_py, r_px};
        wd_vel = {r_vy, r_vx};
        case (i_cmd.op)
            DP_LOAD_WR: begin
                we_pos = 1'b1;
                we_vel = 1'b1;
                wd_pos = {r_ly, r_lx};
                wd_vel = {r_lvy, r_lvx};
            end
            DP_ACC_WR: begin
                we_vel = 1'b1;
                wd_vel = {acc_y, acc_x};
            end
            DP_MOVE: begin
                we_pos = 1'b1;
                wd_pos = {mv_y, mv_x};
            end
            DP_ST_WR: begin
                we_pos = 1'b1;
                we_vel = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_pos) begin
            pos_mem[i_addr] <= wd_pos;
        end
        if (we_vel) begin
            vel_mem[i_addr] <= wd_vel;
        end
        if (i_cmd.op == DP_RD) begin
            r_pos_rd <= pos_mem[i_addr];
            r_vel_rd <= vel_mem[i_addr];
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_CAPTURE: begin
                r_ax     <= i_accel_x;
                r_ay     <= i_accel_y;
                r_lx     <= i_load_x;
                r_ly     <= i_load_y;
                r_lvx    <= i_load_vel_x;
                r_lvy    <= i_load_vel_y;
                r_cx     <= $signed({3'b000, i_query_x, 8'h00});
                r_cy     <= $signed({3'b000, i_query_y, 8'h00});
                r_s0     <= '0;
                r_s1     <= '0;
                r_s2     <= '0;
                r_out_x  <= '0;
                r_out_y  <= '0;
                r_out_vx <= '0;
                r_out_vy <= '0;
                r_dens   <= '0;
                r_gx     <= '0;
                r_gy     <= '0;
            end
            DP_RD_OUT: begin
                r_out_x  <= rd_px;
                r_out_y  <= rd_py;
                r_out_vx <= rd_vx;
                r_out_vy <= rd_vy;
            end
            DP_MOVE: begin
                r_px <= mv_x;
                r_py <= mv_y;
                r_vx <= rd_vx;
                r_vy <= rd_vy;
                r_cx <= D_W'(mv_x);
                r_cy <= D_W'(mv_y);
                r_s0 <= '0;
                r_s1 <= '0;
                r_s2 <= '0;
            end
            DP_MUL_X: begin
                r_prod <= prod[SQ_IN_W-1:0];
            end
            DP_MUL_Y: begin
                r_acc  <= r_prod;
                r_prod <= prod[SQ_IN_W-1:0];
            end
            DP_TERM: begin
                if (term_s > 22'sd0) begin
                    case (i_cmd.smp)
                        SMP_X:   r_s1 <= s_new;
                        SMP_Y:   r_s2 <= s_new;
                        default: r_s0 <= s_new;
                    endcase
                end
            end
            DP_PUSH_X: begin
                r_vx <= push_new;
            end
            DP_PUSH_Y: begin
                r_vy <= push_new;
            end
            DP_WALL_XR, DP_WALL_XL: begin
                if (hit) begin
                    r_vx <= bounce_v;
                    r_px <= wall_newp;
                end
            end
            DP_WALL_YR, DP_WALL_YL: begin
                if (hit) begin
                    r_vy <= bounce_v;
                    r_py <= wall_newp;
                end
            end
            DP_Q_OUT: begin
                r_dens <= r_s0;
                r_gx   <= gx;
                r_gy   <= gy;
            end
            default: begin
            end
        endcase
    end

    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;
    assign o_out_vel_x  = r_out_vx;
    assign o_out_vel_y  = r_out_vy;
    assign o_density    = r_dens;
    assign o_gradient_x = r_gx;
    assign o_gradient_y = r_gy;

endmodule

`default_nettype wire

// File: hw/rtl/pds_ctrl.sv
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: walks particle and neighbor loops and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_density_step_macros.svh"

module pds_ctrl
    import pds_pkg::*;
#(
    parameter int P = PARTICLES_DEF,
    localparam int AW = (P > 1) ? $clog2(P) : 1,
    localparam int CW = $clog2(P + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_start,
    input  logic [2:0]    i_action,
    input  logic [7:0]    i_index,
    input  logic          i_out_free,
    input  t_sts          i_sts,
    output logic          o_ready,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr,
    output logic          o_done
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LOAD    = 5'd1;
    localparam logic [4:0] S_RD      = 5'd2;
    localparam logic [4:0] S_RD_OUT  = 5'd3;
    localparam logic [4:0] S_ACC_RD  = 5'd4;
    localparam logic [4:0] S_ACC_WR  = 5'd5;
    localparam logic [4:0] S_ST_RD   = 5'd6;
    localparam logic [4:0] S_ST_MOVE = 5'd7;
    localparam logic [4:0] S_DN_RD   = 5'd8;
    localparam logic [4:0] S_MX      = 5'd9;
    localparam logic [4:0] S_MY      = 5'd10;
    localparam logic [4:0] S_SQ_ADD  = 5'd11;
    localparam logic [4:0] S_SQ      = 5'd12;
    localparam logic [4:0] S_TERM    = 5'd13;
    localparam logic [4:0] S_PUSHX   = 5'd14;
    localparam logic [4:0] S_PUSHY   = 5'd15;
    localparam logic [4:0] S_WXR     = 5'd16;
    localparam logic [4:0] S_WXL     = 5'd17;
    localparam logic [4:0] S_WYR     = 5'd18;
    localparam logic [4:0] S_WYL     = 5'd19;
    localparam logic [4:0] S_ST_WR   = 5'd20;
    localparam logic [4:0] S_Q_OUT   = 5'd21;
    localparam logic [4:0] S_OUT     = 5'd22;

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [1:0]    r_k, n_k;
    logic [2:0]    r_act, n_act;
    logic [AW-1:0] r_idx, n_idx;

    logic [CW-1:0] cnt_n;
    logic          n_zero, idx_ok, i_last, j_last;

    // Number of particles that take part, limited to the store depth.
    always_comb begin
        if (13'(i_cfg.active_count) > 13'(P)) begin
            cnt_n = CW'(P);
        end else begin
            cnt_n = CW'(i_cfg.active_count);
        end
        n_zero = (cnt_n == '0);
        idx_ok = (13'(i_index) < 13'(P));
        i_last = ((r_i + 1'b1) == cnt_n);
        j_last = ((r_j + 1'b1) == cnt_n);
    end

    // Next state and commands.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_act     = r_act;
        n_idx     = r_idx;
        o_cmd.op  = DP_NOP;
        o_cmd.smp = r_k;
        o_addr    = r_i[AW-1:0];
        o_done    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = DP_CAPTURE;
                    n_act    = i_action;
                    n_idx    = AW'(i_index);
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = SMP_C;
                    case (i_action)
                        ACT_LOAD:  n_state = idx_ok ? S_LOAD : S_OUT;
                        ACT_ACCEL: n_state = n_zero ? S_OUT : S_ACC_RD;
                        ACT_STEP:  n_state = n_zero ? S_OUT : S_ST_RD;
                        ACT_READ:  n_state = idx_ok ? S_RD : S_OUT;
                        ACT_QUERY: n_state = n_zero ? S_Q_OUT : S_DN_RD;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.op = DP_LOAD_WR;
                o_addr   = r_idx;
                n_state  = S_OUT;
            end
            S_RD: begin
                o_cmd.op = DP_RD;
                o_addr   = r_idx;
                n_state  = S_RD_OUT;
            end
            S_RD_OUT: begin
                o_cmd.op = DP_RD_OUT;
                n_state  = S_OUT;
            end
            S_ACC_RD: begin
                o_cmd.op = DP_RD;
                n_state  = S_ACC_WR;
            end
            S_ACC_WR: begin
                o_cmd.op = DP_ACC_WR;
                n_i      = r_i + 1'b1;
                n_state  = i_last ? S_OUT : S_ACC_RD;
            end
            S_ST_RD: begin
                o_cmd.op = DP_RD;
                n_state  = S_ST_MOVE;
            end
            S_ST_MOVE: begin
                o_cmd.op = DP_MOVE;
                n_j      = '0;
                n_state  = S_DN_RD;
            end
            S_DN_RD: begin
                o_cmd.op = DP_RD;
                o_addr   = r_j[AW-1:0];
                n_k      = SMP_C;
                n_state  = S_MX;
            end
            S_MX: begin
                o_cmd.op = DP_MUL_X;
                n_state  = S_MY;
            end
            S_MY: begin
                o_cmd.op = DP_MUL_Y;
                n_state  = S_SQ_ADD;
            end
            S_SQ_ADD: begin
                o_cmd.op = DP_SQ_ADD;
                n_state  = S_SQ;
            end
            S_SQ: begin
                if (i_sts.sq_done) begin
                    n_state = S_TERM;
                end
            end
            S_TERM: begin
                o_cmd.op = DP_TERM;
                if (r_k == SMP_Y) begin
                    if (j_last) begin
                        n_state = (r_act == ACT_STEP) ? S_PUSHX : S_Q_OUT;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = S_DN_RD;
                    end
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_MX;
                end
            end
            S_PUSHX: begin
                o_cmd.op = DP_PUSH_X;
                n_state  = S_PUSHY;
            end
            S_PUSHY: begin
                o_cmd.op = DP_PUSH_Y;
                n_state  = S_WXR;
            end
            S_WXR: begin
                o_cmd.op = DP_WALL_XR;
                n_state  = S_WXL;
            end
            S_WXL: begin
                o_cmd.op = DP_WALL_XL;
                n_state  = S_WYR;
            end
            S_WYR: begin
                o_cmd.op = DP_WALL_YR;
                n_state  = S_WYL;
            end
            S_WYL: begin
                o_cmd.op = DP_WALL_YL;
                n_state  = S_ST_WR;
            end
            S_ST_WR: begin
                o_cmd.op = DP_ST_WR;
                n_i      = r_i + 1'b1;
                n_state  = i_last ? S_OUT : S_ST_RD;
            end
            S_Q_OUT: begin
                o_cmd.op = DP_Q_OUT;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= SMP_C;
            r_act   <= ACT_LOAD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_act   <= n_act;
            r_idx   <= n_idx;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    // An accepted item always starts work.
    `PDS_ASSERT_NEXT(a_start_leaves_idle, i_start, r_state != S_IDLE, "start did not leave idle")
    // Handing over a result returns to idle.
    `PDS_ASSERT_NEXT(a_done_to_idle, o_done, r_state == S_IDLE, "done did not return to idle")
    // The root unit is busy right after a start.
    `PDS_ASSERT_NEXT(a_sqrt_started, o_cmd.op == DP_SQ_ADD, !i_sts.sq_done, "root unit not started")
    // A kernel term is only summed from a finished root.
    `PDS_ASSERT_SAME(a_term_root_ready, r_state == S_TERM, i_sts.sq_done, "root not ready at sum")

endmodule

`default_nettype wire

// File: hw/rtl/particle_density_step.sv
// ----------------------------------------------------------------------------
// particle_density_step
// Particle store with load, accelerate, step, read and density query.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: action; tdata: index, loads, accels, query
//   m_axis    out        tdata: particle, density, gradient
//   cfg       in         register index and write data
//
// One item at a time. Accelerate walks the active particles, a query walks
// them as neighbors and a step walks them as neighbors of each active particle;
// each neighbor costs three distances, each waiting on the root unit.
// Reset is synchronous and active low; the particle stores are not cleared.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_density_step
    import pds_pkg::*;
#(
    parameter int PARTICLES = PARTICLES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] index, [27:8] load_x, [47:28] load_y, [67:48] load_vel_x,
    // [87:68] load_vel_y, [107:88] accel_x, [127:108] accel_y,
    // [138:128] query_x, [149:139] query_y
    input  logic [151:0] s_axis_tdata,
    // [2:0] action
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [19:0] out_x, [39:20] out_y, [59:40] out_vel_x, [79:60] out_vel_y,
    // [103:80] density, [128:104] gradient_x, [153:129] gradient_y
    output logic [159:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

    t_cfg          r_cfg;
    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] addr;
    logic          start, done, out_free, ready;
    logic          r_out_valid;
    logic [159:0]  r_out_data;

    logic signed [Q_W-1:0]    out_x, out_y, out_vx, out_vy;
    logic [DENS_W-1:0]        dens;
    logic signed [GRAD_W-1:0] grad_x, grad_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.area_width      <= 11'd512;
            r_cfg.area_height     <= 11'd512;
            r_cfg.particle_radius <= 4'd2;
            r_cfg.wall_damping    <= 8'd205;
            r_cfg.push_scale      <= 16'd262;
            r_cfg.kern_reach      <= 8'd60;
            r_cfg.active_count    <= 9'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AREA_WIDTH:  r_cfg.area_width      <= i_cfg_data[10:0];
                CFG_AREA_HEIGHT: r_cfg.area_height     <= i_cfg_data[10:0];
                CFG_PART_RADIUS: r_cfg.particle_radius <= i_cfg_data[3:0];
                CFG_WALL_DAMP:   r_cfg.wall_damping    <= i_cfg_data[7:0];
                CFG_PUSH_SCALE:  r_cfg.push_scale      <= i_cfg_data;
                CFG_KERN_RADIUS: r_cfg.kern_reach      <= i_cfg_data[7:0];
                CFG_ACTIVE_CNT:  r_cfg.active_count    <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign start    = s_axis_tvalid && ready;
    assign out_free = !r_out_valid || m_axis_tready;

    pds_ctrl #(
        .P (PARTICLES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_start    (start),
        .i_action   (s_axis_tuser),
        .i_index    (s_axis_tdata[7:0]),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ready    (ready),
        .o_cmd      (cmd),
        .o_addr     (addr),
        .o_done     (done)
    );

    pds_dp #(
        .P (PARTICLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .i_load_x     (s_axis_tdata[27:8]),
        .i_load_y     (s_axis_tdata[47:28]),
        .i_load_vel_x (s_axis_tdata[67:48]),
        .i_load_vel_y (s_axis_tdata[87:68]),
        .i_accel_x    (s_axis_tdata[107:88]),
        .i_accel_y    (s_axis_tdata[127:108]),
        .i_query_x    (s_axis_tdata[138:128]),
        .i_query_y    (s_axis_tdata[149:139]),
        .o_sts        (sts),
        .o_out_x      (out_x),
        .o_out_y      (out_y),
        .o_out_vel_x  (out_vx),
        .o_out_vel_y  (out_vy),
        .o_density    (dens),
        .o_gradient_x (grad_x),
        .o_gradient_y (grad_y)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= {6'b0, grad_y, grad_x, dens, out_vy, out_vx, out_y, out_x};
        end
    end

    assign s_axis_tready = ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: test/particle_density_step_tb.sv
// ----------------------------------------------------------------------------
// particle_density_step_tb
// Self-checking bench for the particle density block.
//
// Drives loads, accelerations, steps, reads, density queries and unused
// actions on the input stream. Register writes happen only between phases.
// A scoreboard keeps its own copy of the particle stores and registers. It
// predicts every output word and checks the output stream field by field.
// Both streams see random gaps. The receiver holds off once for a long
// stretch so that the block backs up onto its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module particle_density_step_tb;
    import pds_pkg::*;

    localparam int  NPART      = 256;
    localparam int  NLOADED    = 16;
    localparam int  HALF_NS    = 6;
    localparam int  MAX_CYCLES = 8000000;
    localparam int  SETTLE     = 40;
    localparam logic [2:0] ACT_SPARE_LO = ACT_QUERY + 3'd1;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]         act;
        logic [7:0]         idx;
        logic signed [19:0] lx, ly, lvx, lvy, ax, ay;
        logic [10:0]        qx, qy;
    } action_word_t;

    // Scoreboard: particle store model and queue of predicted output words.
    class particle_scoreboard;
        longint px[NPART], py[NPART], vx[NPART], vy[NPART];
        longint width_px, height_px, part_rad, damping, push_k, kern_rad, active;
        logic [159:0] pending_words[$];
        int errors;

        function new();
            width_px = 512; height_px = 512; part_rad = 2; damping = 205;
            push_k = 262; kern_rad = 60; active = 256; errors = 0;
            foreach (px[i]) begin
                px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_AREA_WIDTH:  width_px  = data[10:0];
                CFG_AREA_HEIGHT: height_px = data[10:0];
                CFG_PART_RADIUS: part_rad  = data[3:0];
                CFG_WALL_DAMP:   damping   = data[7:0];
                CFG_PUSH_SCALE:  push_k    = data[15:0];
                CFG_KERN_RADIUS: kern_rad  = data[7:0];
                CFG_ACTIVE_CNT:  active    = data[8:0];
                default: ;
            endcase
        endfunction

        function longint sat20(longint v);
            if (v > 524287) return 524287;
            if (v < -524288) return -524288;
            return v;
        endfunction

        function longint int_root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        function int live_count();
            return (active > NPART) ? NPART : int'(active);
        endfunction

        // Sum of the kernel over the active particles at a Q.8 point.
        function longint density_at(longint sx, longint sy);
            longint sum, dx, dy, term;
            sum = 0;
            for (int i = 0; i < live_count(); i++) begin
                dx = px[i] - sx;
                dy = py[i] - sy;
                term = kern_rad * 256 - int_root(longint'(dx * dx + dy * dy));
                if (term > 0) begin
                    sum += term;
                    if (sum > 16777215) sum = 16777215;
                end
            end
            return sum;
        endfunction

        function longint bounced(longint v);
            return sat20((-v * damping + 128) >>> 8);
        endfunction

        function void hit_walls(inout longint p, inout longint v, input longint extent);
            longint lim;
            lim = (extent - part_rad) * 256;
            if (p > lim) begin
                v = bounced(v);
                p = lim;
            end
            if (p <= 0) begin
                v = bounced(v);
                p = 0;
            end
        endfunction

        function void advance_all();
            longint d0, gx, gy, p0, p1, v0, v1;
            for (int i = 0; i < live_count(); i++) begin
                px[i] = sat20(px[i] + vx[i]);
                py[i] = sat20(py[i] + vy[i]);
                d0 = density_at(px[i], py[i]);
                gx = density_at(px[i] + 256, py[i]) - d0;
                gy = density_at(px[i], py[i] + 256) - d0;
                vx[i] = sat20(vx[i] - ((push_k * gx + 32768) >>> 16));
                vy[i] = sat20(vy[i] - ((push_k * gy + 32768) >>> 16));
                p0 = px[i]; v0 = vx[i]; p1 = py[i]; v1 = vy[i];
                hit_walls(p0, v0, width_px);
                hit_walls(p1, v1, height_px);
                px[i] = p0; vx[i] = v0; py[i] = p1; vy[i] = v1;
            end
        endfunction

        // Apply one accepted word to the model and queue its output word.
        function void note_action(action_word_t w);
            logic [159:0] res;
            longint d0, qx, qy;
            res = '0;
            case (w.act)
                ACT_LOAD: begin
                    px[w.idx] = w.lx; py[w.idx] = w.ly;
                    vx[w.idx] = w.lvx; vy[w.idx] = w.lvy;
                end
                ACT_ACCEL: begin
                    for (int i = 0; i < live_count(); i++) begin
                        vx[i] = sat20(vx[i] + longint'(w.ax));
                        vy[i] = sat20(vy[i] + longint'(w.ay));
                    end
                end
                ACT_STEP: advance_all();
                ACT_READ: begin
                    res[19:0]  = px[w.idx][19:0];
                    res[39:20] = py[w.idx][19:0];
                    res[59:40] = vx[w.idx][19:0];
                    res[79:60] = vy[w.idx][19:0];
                end
                ACT_QUERY: begin
                    qx = longint'(w.qx) * 256;
                    qy = longint'(w.qy) * 256;
                    d0 = density_at(qx, qy);
                    res[103:80]  = d0[23:0];
                    res[128:104] = 25'(density_at(qx + 256, qy) - d0);
                    res[153:129] = 25'(density_at(qx, qy + 256) - d0);
                end
                default: ;
            endcase
            pending_words.insert(pending_words.size(), res);
        endfunction

        function void check_word(logic [159:0] got);
            logic [159:0] exp;
            string names[7];
            int lo[7], wid[7];
            names = '{"out_x", "out_y", "out_vel_x", "out_vel_y",
                      "density", "gradient_x", "gradient_y"};
            lo  = '{0, 20, 40, 60, 80, 104, 129};
            wid = '{20, 20, 20, 20, 24, 25, 25};
            if (pending_words.size() == 0) begin
                $error("unexpected output word %h", got);
                errors++;
                return;
            end
            exp = pending_words.pop_front();
            for (int f = 0; f < 7; f++) begin
                if (((exp >> lo[f]) & ((160'd1 << wid[f]) - 1)) !=
                    ((got >> lo[f]) & ((160'd1 << wid[f]) - 1))) begin
                    $error("%s: expected %h, got %h", names[f],
                           (exp >> lo[f]) & ((160'd1 << wid[f]) - 1),
                           (got >> lo[f]) & ((160'd1 << wid[f]) - 1));
                    errors++;
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [15:0]  i_cfg_data;

    particle_scoreboard sb;
    bit  loaded[NPART];
    bit  calm;
    int  hold_off;
    longint cycles;

    particle_density_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(HALF_NS) i_clk = ~i_clk;

    // Gap length: mostly none or short, now and then long.
    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("** particle_density_step: FAILED **");
            $finish;
        end
    end

    // Output side: random stalls plus one long hold-off on request.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                m_axis_tready = 1'b0;
                hold_off--;
            end else if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                stall = gap_len();
            end
        end
    end

    // Check every accepted output word.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end

    // Offer one word after a random gap; valid stays high on return.
    task automatic send_word(action_word_t w);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = w.act;
        s_axis_tdata  = {2'b0, w.qy, w.qx, w.ay, w.ax, w.lvy, w.lvx, w.ly, w.lx, w.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_action(w);
        if (w.act == ACT_LOAD) loaded[w.idx] = 1'b1;
        @(negedge i_clk);
    endtask

    // Wait for every predicted word and let the block settle.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.pending_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function action_word_t blank(logic [2:0] act);
        action_word_t w;
        w.act = act; w.idx = '0; w.lx = '0; w.ly = '0; w.lvx = '0; w.lvy = '0;
        w.ax = '0; w.ay = '0; w.qx = '0; w.qy = '0;
        return w;
    endfunction

    task automatic do_load(int idx, int x, int y, int vx, int vy);
        action_word_t w;
        w = blank(ACT_LOAD);
        w.idx = 8'(idx); w.lx = 20'(x); w.ly = 20'(y); w.lvx = 20'(vx); w.lvy = 20'(vy);
        w.ax = 20'($urandom); w.ay = 20'($urandom);
        w.qx = 11'($urandom); w.qy = 11'($urandom);
        send_word(w);
    endtask

    task automatic do_simple(logic [2:0] act, int idx = 0);
        action_word_t w;
        w = blank(act);
        w.idx = 8'(idx);
        send_word(w);
    endtask

    task automatic do_accel(int ax, int ay);
        action_word_t w;
        w = blank(ACT_ACCEL);
        w.ax = 20'(ax); w.ay = 20'(ay);
        send_word(w);
    endtask

    task automatic do_query(int qx, int qy);
        action_word_t w;
        w = blank(ACT_QUERY);
        w.qx = 11'(qx); w.qy = 11'(qy);
        send_word(w);
    endtask

    // Position mostly inside a crowded corner, sometimes anywhere.
    function int rand_pos();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 80 * 256);
        return $signed(20'($urandom));
    endfunction

    function int rand_vel();
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2048) - 1024;
        return $signed(20'($urandom));
    endfunction

    task automatic random_word();
        action_word_t w;
        int r;
        r = $urandom_range(0, 99);
        w.idx = 8'($urandom); w.lx = 20'($urandom); w.ly = 20'($urandom);
        w.lvx = 20'($urandom); w.lvy = 20'($urandom);
        w.ax = 20'($urandom); w.ay = 20'($urandom);
        w.qx = 11'($urandom); w.qy = 11'($urandom);
        if (r < 25) begin
            w.act = ACT_LOAD;
            w.lx = 20'(rand_pos()); w.ly = 20'(rand_pos());
            w.lvx = 20'(rand_vel()); w.lvy = 20'(rand_vel());
        end else if (r < 35) begin
            w.act = ACT_ACCEL;
            w.ax = 20'(rand_vel()); w.ay = 20'(rand_vel());
        end else if (r < 50) begin
            w.act = ACT_STEP;
        end else if (r < 73) begin
            w.act = ACT_READ;
            while (!loaded[w.idx]) w.idx = 8'($urandom);
        end else if (r < 95) begin
            w.act = ACT_QUERY;
            if ($urandom_range(0, 3) != 0) begin
                w.qx = 11'($urandom_range(0, 90));
                w.qy = 11'($urandom_range(0, 90));
            end
        end else begin
            w.act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        end
        send_word(w);
    endtask

    initial begin
        int act_n;
        sb = new();
        cycles = 0;
        hold_off = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_LOAD;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_AREA_WIDTH;
        i_cfg_data = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: field extremes, every action, saturation and bounces.
        write_reg(CFG_ACTIVE_CNT, 16'd8);
        do_load(0, 524287, -524288, -524288, 524287);
        do_load(1, 10 * 256, 10 * 256, 300, -300);
        for (int i = 2; i < NLOADED; i++) do_load(i, (12 + i) * 256, (8 + 2 * i) * 256, 0, 0);
        do_simple(ACT_READ, 0);
        do_accel(524287, -524288);
        do_accel(-524288, 524287);
        do_query(0, 0);
        do_query(2047, 2047);
        do_query(14, 14);
        do_simple(ACT_STEP);
        do_simple(ACT_READ, 1);
        do_simple(ACT_READ, 0);
        do_simple(ACT_SPARE_LO);
        do_simple(ACT_SPARE_HI);
        do_load(255, 524287, 524287, 524287, -524288);
        do_simple(ACT_READ, 255);
        drain();

        // No particle taking part.
        write_reg(CFG_ACTIVE_CNT, 16'd0);
        do_simple(ACT_STEP);
        do_query(5, 5);
        drain();

        // Random phases with fresh settings, extremes first.
        for (int ph = 0; ph < 4; ph++) begin
            calm = (ph == 3);
            case (ph)
                0: begin
                    write_reg(CFG_AREA_WIDTH, 16'd1);  write_reg(CFG_AREA_HEIGHT, 16'd1);
                    write_reg(CFG_PART_RADIUS, 16'd15); write_reg(CFG_WALL_DAMP, 16'd0);
                    write_reg(CFG_PUSH_SCALE, 16'd0);  write_reg(CFG_KERN_RADIUS, 16'd1);
                    act_n = 1;
                end
                1: begin
                    write_reg(CFG_AREA_WIDTH, 16'd2047); write_reg(CFG_AREA_HEIGHT, 16'd2047);
                    write_reg(CFG_PART_RADIUS, 16'd0);   write_reg(CFG_WALL_DAMP, 16'd255);
                    write_reg(CFG_PUSH_SCALE, 16'hFFFF); write_reg(CFG_KERN_RADIUS, 16'd255);
                    act_n = 12;
                end
                default: begin
                    write_reg(CFG_AREA_WIDTH,
                              16'(($urandom & 16'hF800) | $urandom_range(20, 120)));
                    write_reg(CFG_AREA_HEIGHT,
                              16'(($urandom & 16'hF800) | $urandom_range(20, 120)));
                    write_reg(CFG_PART_RADIUS, 16'($urandom));
                    write_reg(CFG_WALL_DAMP, 16'($urandom));
                    write_reg(CFG_PUSH_SCALE, 16'($urandom));
                    write_reg(CFG_KERN_RADIUS,
                              16'(($urandom & 16'hFF00) | $urandom_range(1, 255)));
                    act_n = $urandom_range(2, NLOADED);
                end
            endcase
            write_reg(CFG_ACTIVE_CNT, 16'(act_n));
            for (int k = 0; k < 16; k++) begin
                if (ph == 1 && k == 4) hold_off = 40000;
                random_word();
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("** particle_density_step: PASSED **");
        end else begin
            $display("** particle_density_step: FAILED **");
        end
        $finish;
    end

endmodule
